// ===== hdl/sitda_pkg.sv =====
// Shared constants and types for the signed integer to decimal text converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sitda_pkg;

	localparam int VALUE_W       = 32;
	localparam int CHAR_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int DIGITS        = 10;
	localparam int BCD_W         = DIGITS * DIGIT_W;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int CNT_W         = $clog2(STEPS);
	localparam int IDX_W         = $clog2(DIGITS);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

	typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/sitda_if.sv =====
// Valid/ready channel interfaces: integer items in, character items out.
// Depends on sitda_pkg for field widths.
`default_nettype none

interface sitda_in_if;
	import sitda_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
	import sitda_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last_char;

	modport source (output valid, output text_char, output last_char, input ready);
	modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== hdl/sitda_dabble.sv =====
// Shift-and-add-3 step of the binary to BCD conversion, several bits per call.
// Depends on sitda_pkg for digit count and step width.
`default_nettype none

module sitda_dabble (
	input  sitda_pkg::bcd_t                          bcd_i,
	input  logic [sitda_pkg::BITS_PER_STEP-1:0]      bits_i,
	output sitda_pkg::bcd_t                          bcd_o
);
	import sitda_pkg::*;

	// Per bit: correct digits of five or more, then shift the next bit in, MSB first
	always_comb begin
		logic [BCD_W-1:0] acc;
		acc = bcd_i;
		for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (acc[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
					acc[d*DIGIT_W +: DIGIT_W] = acc[d*DIGIT_W +: DIGIT_W] + 4'd3;
				end
			end
			acc = {acc[BCD_W-2:0], bits_i[b]};
		end
		bcd_o = acc;
	end

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// Depends on sitda_pkg, sitda_if (channel interfaces) and sitda_dabble.
//
// Usage:
//   din carries one signed 32-bit value per item. dout returns its decimal
//   text most significant digit first: an optional '-', then the digits with
//   no leading zeros ('0' for zero). last_char marks the final character.
// Timing:
//   An accepted value passes through the shared shift-add-3 unit (4 bits
//   of magnitude per cycle) and then a state that locates the leading digit;
//   the characters (1 to 11 per number) then follow one per cycle while dout
//   is ready. din.ready is high only between numbers; the next value can be
//   taken in the cycle after the last character is accepted.
// Reset:
//   arst_n clears the sequencer; the block comes up ready with dout idle.
// Stall:
//   A low dout.ready holds the current character and its marker unchanged.
`default_nettype none

module signed_int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	sitda_in_if.sink           din,
	sitda_out_if.source        dout
);
	import sitda_pkg::*;

	state_t             state_q, state_d;
	logic [VALUE_W-1:0] bin_q;
	bcd_t               bcd_q;
	bcd_t               bcd_step;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   lead_idx;
	logic               sign_q;
	logic               in_fire;
	logic               out_fire;
	logic               last_step;
	logic               final_char;

	assign in_fire    = din.valid && din.ready;
	assign out_fire   = dout.valid && dout.ready;
	assign last_step  = (cnt_q == CNT_W'(STEPS - 1));
	assign final_char = !sign_q && (idx_q == '0);

	// Shared conversion step fed from the top of the magnitude register
	sitda_dabble u_dabble (
		.bcd_i  (bcd_q),
		.bits_i (bin_q[VALUE_W-1 -: BITS_PER_STEP]),
		.bcd_o  (bcd_step)
	);

	// Locate the highest nonzero digit; zero keeps position 0
	always_comb begin
		lead_idx = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d] != '0) begin
				lead_idx = IDX_W'(d);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (din.valid) state_d = ST_CONV;
			ST_CONV: if (last_step) state_d = ST_FIND;
			ST_FIND: state_d = ST_EMIT;
			ST_EMIT: if (dout.ready && final_char) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Channel outputs
	always_comb begin
		din.ready      = (state_q == ST_IDLE);
		dout.valid     = (state_q == ST_EMIT);
		dout.last_char = final_char;
		if (sign_q) begin
			dout.text_char = CH_MINUS;
		end else begin
			dout.text_char = CH_ZERO + CHAR_W'(bcd_q[idx_q]);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			sign_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cnt_q  <= '0;
				sign_q <= din.value[VALUE_W-1];
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_FIND) begin
				idx_q <= lead_idx;
			end else if (out_fire) begin
				// drop the sign first, then walk down the digits
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
		end
	end

	// Magnitude and BCD accumulator
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bin_q <= din.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(din.value))
			                              : VALUE_W'(din.value);
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= bin_q << BITS_PER_STEP;
			bcd_q <= bcd_step;
		end
	end

	// Checks
	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		din.ready |-> !dout.valid)
		else $error("input ready while a character is pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.ready && dout.last_char) |=> din.ready)
		else $error("not ready after the final character");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.text_char == CH_MINUS) |-> !dout.last_char)
		else $error("minus sign marked as final character");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q <= IDX_W'(DIGITS - 1)))
		else $error("digit index out of range");

	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> ##(STEPS) (state_q == ST_FIND))
		else $error("conversion did not finish in the expected cycles");

endmodule

`default_nettype wire

// ===== dv/signed_int_to_decimal_ascii_test.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: drives signed integers and
// checks every decimal text character and its end marker against a local predictor.
// Depends on sitda_pkg, sitda_if and the block itself.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_test;
	import sitda_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              last_char;
	} text_item_t;

	logic clk = 1'b0;
	logic arst_n;

	sitda_in_if  din_ch ();
	sitda_out_if dout_ch ();

	signed_int_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	logic [VALUE_W-1:0] pending_values[$];
	text_item_t         expected_text[$];
	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 num_values     = 0;
	int                 num_chars      = 0;
	int                 num_errors     = 0;

	always #10 clk = ~clk;

	// Queue the expected characters of one number, sign first, then digits MSD first
	function automatic void predict_decimal_text(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  digits[$];
		text_item_t         item;
		begin
			mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
			do begin
				digits.push_front(CH_ZERO + CHAR_W'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (raw[VALUE_W-1]) begin
				item.text_char = CH_MINUS;
				item.last_char = 1'b0;
				expected_text.push_back(item);
			end
			foreach (digits[i]) begin
				item.text_char = digits[i];
				item.last_char = (i == digits.size() - 1);
				expected_text.push_back(item);
			end
		end
	endfunction

	// Pick a random value: raw bits, short magnitudes, powers of ten, or near the extremes
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		int unsigned        lim;
		int                 k;
		begin
			k   = $urandom_range(9, 1);
			lim = 1;
			for (int i = 0; i < k; i++)
				lim = lim * 10;
			case ($urandom_range(3, 0))
				0: v = $urandom;
				1: v = $urandom_range(lim - 1, 0);
				2: v = (k == 9 && $urandom_range(1, 0)) ? 32'd1000000000 + $urandom_range(2, 0) - 1
				   : lim + $urandom_range(2, 0) - 1;
				default: v = $urandom_range(1, 0) ? 32'h8000_0000 + $urandom_range(3, 0)
				         : 32'h7FFF_FFFF - $urandom_range(3, 0);
			endcase
			if ($urandom_range(1, 0) && v != 32'h8000_0000)
				v = ~v + 1'b1;
			return v;
		end
	endfunction

	// Drive the input channel; record each accepted item in the predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_ch.valid <= 1'b0;
			din_ch.value <= '0;
		end else begin
			if (din_ch.valid && din_ch.ready) begin
				predict_decimal_text(din_ch.value);
				num_values++;
			end
			if (!din_ch.valid || din_ch.ready) begin
				if (pending_values.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					din_ch.valid <= 1'b1;
					din_ch.value <= pending_values.pop_front();
				end else begin
					din_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Stall the output channel at random and check each accepted character
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_ch.ready <= 1'b0;
		end else begin
			if (dout_ch.valid && dout_ch.ready) begin
				num_chars++;
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character: got char %0d last %0b",
						$time, dout_ch.text_char, dout_ch.last_char);
					num_errors++;
				end else begin
					text_item_t exp_item;
					exp_item = expected_text.pop_front();
					if (dout_ch.text_char !== exp_item.text_char) begin
						$display("%0t: text_char mismatch: expected %0d, got %0d",
							$time, exp_item.text_char, dout_ch.text_char);
						num_errors++;
					end
					if (dout_ch.last_char !== exp_item.last_char) begin
						$display("%0t: last_char mismatch: expected %0b, got %0b",
							$time, exp_item.last_char, dout_ch.last_char);
						num_errors++;
					end
				end
			end
			dout_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Hold until every queued number is sent and all its characters are back;
	// look between rising edges so the driver's updates have settled
	task automatic drain_phase();
		while (pending_values.size() != 0 || din_ch.valid || expected_text.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int idle_table[4];
		int stall_table[4];
		logic [VALUE_W-1:0] directed[$];

		idle_table  = '{0, 50, 0, 16};
		stall_table = '{0, 0, 50, 16};
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
			32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'sd999999999, -32'sd1000000000, 32'd123456789,
			-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd5, 32'd4294967286,
			32'd2000000000};

		arst_n        = 1'b0;
		din_ch.valid  = 1'b0;
		din_ch.value  = '0;
		dout_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed corners first, with no idling
		foreach (directed[i])
			pending_values.push_back(directed[i]);
		drain_phase();

		// Random numbers under each flow-control mix
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_table[ph];
			recv_stall_pct = stall_table[ph];
			for (int n = 0; n < 105; n++)
				pending_values.push_back(pick_value());
			drain_phase();
		end

		repeat (40) @(posedge clk);
		$display("Converted %0d numbers into %0d characters under four idle/stall mixes",
			num_values, num_chars);
		if (num_errors == 0 && expected_text.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("Timeout with %0d characters outstanding", expected_text.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
